FILE: hw/rtl/tlpd_pkg.sv
// ----------------------------------------------------------------------------
// tlpd_pkg
// Shared types, event codes and helpers for the two-button long-press
// detector.
// ----------------------------------------------------------------------------
package tlpd_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int MAX_EVENTS  = 4;
  localparam int EV_CNT_W    = $clog2(MAX_EVENTS + 1);
  localparam int EV_IDX_W    = $clog2(MAX_EVENTS);

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [CFG_WIDTH-1:0]   cfg_t;

  localparam cfg_t LONG_PRESS_RESET = cfg_t'(2000);

  localparam logic [1:0] KEY_ONE   = 2'd0;
  localparam logic [1:0] KEY_TWO   = 2'd1;
  localparam logic [1:0] KEY_COMBO = 2'd2;

  localparam logic [3:0] VAL_RELEASE   = 4'h0;
  localparam logic [3:0] VAL_PRESS_ONE = 4'h4;
  localparam logic [3:0] VAL_PRESS_TWO = 4'h5;
  localparam logic [3:0] VAL_COMBO     = 4'h8;

  typedef struct packed {
    logic press;
    logic release_edge;
    logic expired;
    logic held;
    logic led_cur;
    logic led;
  } lane_status_t;

  typedef struct packed {
    logic [1:0] key;
    logic [3:0] value;
    logic       led1;
    logic       led2;
    logic       last;
  } event_t;

  function automatic count_t load_value(input cfg_t ticks);
    if (COUNT_WIDTH >= CFG_WIDTH) begin
      return count_t'(ticks);
    end else if (ticks > cfg_t'({COUNT_WIDTH{1'b1}})) begin
      return {COUNT_WIDTH{1'b1}};
    end else begin
      return count_t'(ticks);
    end
  endfunction

endpackage

FILE: hw/rtl/tlpd_lane.sv
// ----------------------------------------------------------------------------
// tlpd_lane
// One button lane: edge detection, held mark, LED toggle and long-press
// countdown.
// ----------------------------------------------------------------------------
module tlpd_lane (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic                  level,
  input  tlpd_pkg::count_t      load,
  output tlpd_pkg::lane_status_t status
);
  import tlpd_pkg::*;

  logic   held, held_next;
  logic   led, led_next;
  logic   active, active_next;
  count_t count, count_next;
  logic   press, rel, expired;

  assign press   = !level && !held;
  assign rel     = level && held;
  assign expired = !press && !rel && active && (count <= count_t'(1));

  always_comb begin
    held_next   = held;
    led_next    = led;
    active_next = active;
    count_next  = count;
    if (press) begin
      held_next   = 1'b1;
      led_next    = !led;
      active_next = 1'b1;
      count_next  = load;
    end else if (rel) begin
      held_next   = 1'b0;
      active_next = 1'b0;
      count_next  = '0;
    end else if (active) begin
      if (expired) begin
        active_next = 1'b0;
        count_next  = '0;
      end else begin
        count_next = count - count_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held   <= 1'b0;
      led    <= 1'b1;
      active <= 1'b0;
      count  <= '0;
    end else if (accept) begin
      held   <= held_next;
      led    <= led_next;
      active <= active_next;
      count  <= count_next;
    end
  end

  assign status.press        = press;
  assign status.release_edge = rel;
  assign status.expired      = expired;
  assign status.held         = held_next;
  assign status.led_cur      = led;
  assign status.led          = led_next;

endmodule

FILE: hw/rtl/tlpd_merge.sv
// ----------------------------------------------------------------------------
// tlpd_merge
// Combines both lanes into the ordered event list of one tick and holds it
// while its beats drain one per cycle whenever the output is not stalled.
// ----------------------------------------------------------------------------
module tlpd_merge (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  tlpd_pkg::lane_status_t lane1,
  input  tlpd_pkg::lane_status_t lane2,
  input  logic                   pop,
  output logic                   room,
  output logic                   has,
  output tlpd_pkg::event_t       head
);
  import tlpd_pkg::*;

  event_t                slot_new [MAX_EVENTS];
  logic [EV_CNT_W-1:0]   n_new;
  event_t                slot [MAX_EVENTS];
  logic [EV_CNT_W-1:0]   remain;
  logic [EV_IDX_W-1:0]   idx;
  logic                  combo;

  assign combo = (lane1.expired || lane2.expired) && lane1.held && lane2.held;

  always_comb begin
    for (int i = 0; i < MAX_EVENTS; i++) begin
      slot_new[i] = '0;
    end
    n_new = '0;
    if (lane1.press || lane1.release_edge) begin
      slot_new[n_new[EV_IDX_W-1:0]].key   = KEY_ONE;
      slot_new[n_new[EV_IDX_W-1:0]].value = lane1.press ? VAL_PRESS_ONE : VAL_RELEASE;
      slot_new[n_new[EV_IDX_W-1:0]].led1  = lane1.led;
      slot_new[n_new[EV_IDX_W-1:0]].led2  = lane2.led_cur;
      n_new = n_new + EV_CNT_W'(1);
    end
    if (lane2.press || lane2.release_edge) begin
      slot_new[n_new[EV_IDX_W-1:0]].key   = KEY_TWO;
      slot_new[n_new[EV_IDX_W-1:0]].value = lane2.press ? VAL_PRESS_TWO : VAL_RELEASE;
      slot_new[n_new[EV_IDX_W-1:0]].led1  = lane1.led;
      slot_new[n_new[EV_IDX_W-1:0]].led2  = lane2.led;
      n_new = n_new + EV_CNT_W'(1);
    end
    if (combo) begin
      slot_new[n_new[EV_IDX_W-1:0]].key   = KEY_COMBO;
      slot_new[n_new[EV_IDX_W-1:0]].value = VAL_COMBO;
      slot_new[n_new[EV_IDX_W-1:0]].led1  = lane1.led;
      slot_new[n_new[EV_IDX_W-1:0]].led2  = lane2.led;
      n_new = n_new + EV_CNT_W'(1);
      slot_new[n_new[EV_IDX_W-1:0]].key   = KEY_COMBO;
      slot_new[n_new[EV_IDX_W-1:0]].value = VAL_RELEASE;
      slot_new[n_new[EV_IDX_W-1:0]].led1  = lane1.led;
      slot_new[n_new[EV_IDX_W-1:0]].led2  = lane2.led;
      n_new = n_new + EV_CNT_W'(1);
    end
    if (n_new != '0) begin
      slot_new[n_new[EV_IDX_W-1:0] - EV_IDX_W'(1)].last = 1'b1;
    end
  end

  assign has  = (remain != '0);
  assign room = (remain == '0) || ((remain == EV_CNT_W'(1)) && pop);
  assign head = slot[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
      idx    <= '0;
    end else if (accept) begin
      remain <= n_new;
      idx    <= '0;
    end else if (pop) begin
      remain <= remain - EV_CNT_W'(1);
      idx    <= idx + EV_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MAX_EVENTS; i++) begin
        slot[i] <= slot_new[i];
      end
    end
  end

endmodule

FILE: hw/rtl/two_button_long_press_detector_unit.sv
// ----------------------------------------------------------------------------
// two_button_long_press_detector_unit
// Two-button press, release and combo long-press event generator.
// ----------------------------------------------------------------------------
// Each input beat is one tick with the active-low levels of both buttons. A
// tick that yields at most one event is taken every cycle while the output
// is not stalled; a tick that yields more (up to three: a button edge, combo
// press and combo release) holds the input while its event list drains one
// beat per unstalled cycle into the output register, and the next tick is
// taken in the cycle its last beat moves out. long_press_ticks sets how many
// ticks a button stays held before its countdown expires; write it only
// while the block is idle.
// ----------------------------------------------------------------------------
module two_button_long_press_detector_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [15:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       button1_level,
  input  logic       button2_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] event_key,
  output logic [3:0] event_value,
  output logic       led1_on,
  output logic       led2_on,
  output logic       last_event
);
  import tlpd_pkg::*;

  cfg_t         long_press_ticks;
  count_t       load;
  logic         accept;
  logic         room, has, pop;
  lane_status_t lane1, lane2;
  event_t       head;
  event_t       out_ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= LONG_PRESS_RESET;
    end else if (cfg_write) begin
      long_press_ticks <= cfg_data;
    end
  end

  assign load     = load_value(long_press_ticks);
  assign in_stall = !room;
  assign accept   = in_valid && room;
  assign pop      = has && (!out_valid || !out_stall);

  tlpd_lane u_lane1 (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .level  (button1_level),
    .load   (load),
    .status (lane1)
  );

  tlpd_lane u_lane2 (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .level  (button2_level),
    .load   (load),
    .status (lane2)
  );

  tlpd_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .lane1  (lane1),
    .lane2  (lane2),
    .pop    (pop),
    .room   (room),
    .has    (has),
    .head   (head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_ev <= head;
    end
  end

  assign event_key   = out_ev.key;
  assign event_value = out_ev.value;
  assign led1_on     = out_ev.led1;
  assign led2_on     = out_ev.led2;
  assign last_event  = out_ev.last;

endmodule

FILE: test/tb_two_button_long_press_detector_unit.sv
// ----------------------------------------------------------------------------
// tb_two_button_long_press_detector_unit
// Self-checking testbench for the two-button long-press detector.
// ----------------------------------------------------------------------------
// Ticks with both button levels go in over a valid/stall channel. A cycle
// model of the detector runs beside it and queues the events that each
// accepted tick should raise. A checker compares every event beat taken off
// the output against the oldest queued event, field by field. Directed tests
// cover the reset setting, presses and releases, combo long presses,
// expiry on one tick for both buttons, release on the expiry tick, expiry
// with one button held, a zero and a full-scale setting and back-pressure.
// Random press sequences and noise follow under several settings, with
// random idle bursts on both channels in all but the last run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_two_button_long_press_detector_unit;
  import tlpd_pkg::*;

  logic       clk;
  logic       rst;
  logic       cfg_write;
  logic [15:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic       button1_level;
  logic       button2_level;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] event_key;
  logic [3:0] event_value;
  logic       led1_on;
  logic       led2_on;
  logic       last_event;

  two_button_long_press_detector_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .button1_level (button1_level),
    .button2_level (button2_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_key     (event_key),
    .event_value   (event_value),
    .led1_on       (led1_on),
    .led2_on       (led2_on),
    .last_event    (last_event)
  );

  // Detector state as predicted
  cfg_t       press_ticks;
  logic       btn1_held;
  logic       btn2_held;
  logic       led1_state;
  logic       led2_state;
  count_t     hold_count1;
  count_t     hold_count2;
  logic       hold_active1;
  logic       hold_active2;

  event_t     expected_events[$];

  int         error_count;
  int         ticks_sent;
  int         events_checked;
  int         combos_seen;
  int         settings_used;
  int         hold_request;
  bit         sender_idle_on;
  bit         receiver_idle_on;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic event_t make_event(input logic [1:0] key, input logic [3:0] value);
    event_t ev;
    ev.key   = key;
    ev.value = value;
    ev.led1  = led1_state;
    ev.led2  = led2_state;
    ev.last  = 1'b0;
    return ev;
  endfunction

  function automatic void predict_events(input logic lvl1, input logic lvl2);
    event_t evs[$];
    logic   new1;
    logic   new2;
    logic   exp1;
    logic   exp2;
    new1 = 1'b0;
    new2 = 1'b0;
    exp1 = 1'b0;
    exp2 = 1'b0;
    if (!lvl1 && !btn1_held) begin
      btn1_held    = 1'b1;
      led1_state   = !led1_state;
      evs.push_back(make_event(KEY_ONE, VAL_PRESS_ONE));
      hold_count1  = count_t'(press_ticks);
      hold_active1 = 1'b1;
      new1         = 1'b1;
    end else if (lvl1 && btn1_held) begin
      btn1_held    = 1'b0;
      evs.push_back(make_event(KEY_ONE, VAL_RELEASE));
      hold_count1  = '0;
      hold_active1 = 1'b0;
    end
    if (!lvl2 && !btn2_held) begin
      btn2_held    = 1'b1;
      led2_state   = !led2_state;
      evs.push_back(make_event(KEY_TWO, VAL_PRESS_TWO));
      hold_count2  = count_t'(press_ticks);
      hold_active2 = 1'b1;
      new2         = 1'b1;
    end else if (lvl2 && btn2_held) begin
      btn2_held    = 1'b0;
      evs.push_back(make_event(KEY_TWO, VAL_RELEASE));
      hold_count2  = '0;
      hold_active2 = 1'b0;
    end
    if (!new1 && hold_active1) begin
      if (hold_count1 <= 1) begin
        hold_count1  = '0;
        hold_active1 = 1'b0;
        exp1         = 1'b1;
      end else begin
        hold_count1 = hold_count1 - 1'b1;
      end
    end
    if (!new2 && hold_active2) begin
      if (hold_count2 <= 1) begin
        hold_count2  = '0;
        hold_active2 = 1'b0;
        exp2         = 1'b1;
      end else begin
        hold_count2 = hold_count2 - 1'b1;
      end
    end
    if ((exp1 || exp2) && btn1_held && btn2_held) begin
      evs.push_back(make_event(KEY_COMBO, VAL_COMBO));
      evs.push_back(make_event(KEY_COMBO, VAL_RELEASE));
    end
    if (evs.size() > 0) begin
      evs[evs.size()-1].last = 1'b1;
    end
    foreach (evs[i]) begin
      expected_events.push_back(evs[i]);
    end
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    event_t ev;
    if (!rst && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        error_count++;
        $display("%0t: unexpected event beat, expected none, actual key %0d value %0d",
                 $time, event_key, event_value);
      end else begin
        ev = expected_events.pop_front();
        check_field("event_key", int'(ev.key), int'(event_key));
        check_field("event_value", int'(ev.value), int'(event_value));
        check_field("led1_on", int'(ev.led1), int'(led1_on));
        check_field("led2_on", int'(ev.led2), int'(led2_on));
        check_field("last_event", int'(ev.last), int'(last_event));
        events_checked++;
        if (ev.key == KEY_COMBO && ev.value == VAL_COMBO) begin
          combos_seen++;
        end
      end
    end
  end

  // Output side: random stall bursts, plus a long hold on request
  initial begin
    int len;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        len = hold_request;
        hold_request = 0;
        out_stall <= 1'b1;
        repeat (len) @(negedge clk);
        out_stall <= 1'b0;
      end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
        len = $urandom_range(1, 15);
        out_stall <= 1'b1;
        repeat (len) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_tick(input logic lvl1, input logic lvl2);
    int gap;
    if (sender_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    button1_level <= lvl1;
    button2_level <= lvl2;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_events(lvl1, lvl2);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic drain_events;
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_press_ticks(input cfg_t value);
    drain_events();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    press_ticks = value;
    settings_used++;
  endtask

  task automatic test_press_release_default;
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
  endtask

  task automatic test_default_long_press;
    sender_idle_on = 1'b0;
    send_tick(1'b0, 1'b0);
    repeat (20) send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    sender_idle_on = 1'b1;
  endtask

  task automatic test_same_tick_expiry;
    write_press_ticks(cfg_t'(1));
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
  endtask

  task automatic test_release_on_expiry;
    write_press_ticks(cfg_t'(2));
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
  endtask

  task automatic test_single_held_expiry;
    write_press_ticks(cfg_t'(3));
    send_tick(1'b0, 1'b1);
    repeat (4) send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    repeat (3) send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
  endtask

  task automatic test_zero_ticks;
    write_press_ticks(cfg_t'(0));
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
  endtask

  task automatic test_full_scale_ticks;
    write_press_ticks(cfg_t'(16'hFFFF));
    send_tick(1'b0, 1'b0);
    repeat (8) send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
  endtask

  task automatic test_backpressure;
    write_press_ticks(cfg_t'(1));
    @(posedge clk);
    hold_request = 80;
    @(negedge clk);
    repeat (8) begin
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b1);
    end
  endtask

  task automatic press_sequence;
    int order;
    int gap;
    int hold;
    int rel;
    order = $urandom_range(0, 2);
    gap   = $urandom_range(0, int'(press_ticks) + 1);
    hold  = $urandom_range(0, int'(press_ticks) + 2);
    rel   = $urandom_range(0, 2);
    send_tick(1'b1, 1'b1);
    case (order)
      0: begin
        send_tick(1'b0, 1'b1);
        repeat (gap) send_tick(1'b0, 1'b1);
      end
      1: begin
        send_tick(1'b1, 1'b0);
        repeat (gap) send_tick(1'b1, 1'b0);
      end
      default: ;
    endcase
    send_tick(1'b0, 1'b0);
    repeat (hold) send_tick(1'b0, 1'b0);
    case (rel)
      0: send_tick(1'b1, 1'b0);
      1: send_tick(1'b0, 1'b1);
      default: ;
    endcase
    send_tick(1'b1, 1'b1);
  endtask

  task automatic test_random_sequences(input cfg_t ticks, input int count, input bit idle);
    int target;
    write_press_ticks(ticks);
    sender_idle_on   = idle;
    receiver_idle_on = idle;
    target = ticks_sent + count;
    while (ticks_sent < target) begin
      if ($urandom_range(0, 3) != 0) begin
        press_sequence();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end
    end
  endtask

  initial begin
    #5_000_000;
    $display("FAIL two_button_long_press_detector_unit");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    button1_level = 1'b1;
    button2_level = 1'b1;
    hold_request  = 0;
    error_count   = 0;
    ticks_sent    = 0;
    events_checked = 0;
    combos_seen   = 0;
    settings_used = 1;
    press_ticks   = LONG_PRESS_RESET;
    btn1_held     = 1'b0;
    btn2_held     = 1'b0;
    led1_state    = 1'b1;
    led2_state    = 1'b1;
    hold_count1   = '0;
    hold_count2   = '0;
    hold_active1  = 1'b0;
    hold_active2  = 1'b0;
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_press_release_default();
    test_default_long_press();
    test_same_tick_expiry();
    test_release_on_expiry();
    test_single_held_expiry();
    test_zero_ticks();
    test_full_scale_ticks();
    test_backpressure();
    test_random_sequences(cfg_t'(1), 20, 1'b1);
    test_random_sequences(cfg_t'(3), 20, 1'b1);
    test_random_sequences(cfg_t'($urandom_range(2, 6)), 20, 1'b1);
    test_random_sequences(cfg_t'(2), 20, 1'b0);

    drain_events();
    repeat (10) @(posedge clk);
    if (expected_events.size() != 0) begin
      error_count++;
      $display("%0t: %0d events never arrived", $time, expected_events.size());
    end
    $display("Run covered %0d ticks under %0d long-press settings,", ticks_sent, settings_used);
    $display("with %0d events checked and %0d combo long presses.", events_checked, combos_seen);
    if (error_count == 0) begin
      $display("PASS two_button_long_press_detector_unit");
    end else begin
      $display("FAIL two_button_long_press_detector_unit");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/tlpd_pkg.sv
hw/rtl/tlpd_lane.sv
hw/rtl/tlpd_merge.sv
hw/rtl/two_button_long_press_detector_unit.sv
test/tb_two_button_long_press_detector_unit.sv
